### rtl/mcpl_pkg.sv
// Shared types and constants of the mip chain pitch layout block.
package mcpl_pkg;

    // Geometry limits and pitch alignment
    localparam int MAX_MIP_LEVELS = 15;
    localparam int MAX_DIMENSION  = 16384;
    localparam int PITCH_ALIGN    = 256;

    // Field widths
    localparam int DIM_W    = 15;
    localparam int TB_W     = 6;
    localparam int LAYER_W  = 16;
    localparam int LVL_W    = 4;
    localparam int OFFSET_W = 35;
    localparam int PITCH_W  = 20;
    localparam int TOTAL_W  = 51;

    // Shared multiplier geometry
    localparam int MUL_A_W  = 20;
    localparam int MUL_B_W  = 16;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int SUM_W    = 36;
    localparam int HALF_W   = SUM_W / 2;

    typedef struct packed {
        logic [DIM_W-1:0]   tex_width;
        logic [DIM_W-1:0]   tex_height;
        logic [TB_W-1:0]    texel_bytes;
        logic [LAYER_W-1:0] layer_count;
        logic [LVL_W-1:0]   mip_levels;
    } t_req;

    typedef struct packed {
        logic [LVL_W-1:0]    level_index;
        logic [OFFSET_W-1:0] level_offset;
        logic [PITCH_W-1:0]  line_pitch;
        logic [DIM_W-1:0]    level_width;
        logic [DIM_W-1:0]    level_height;
        logic [OFFSET_W-1:0] chain_bytes;
        logic [TOTAL_W-1:0]  total_bytes;
        logic                error;
        logic                last;
    } t_res;

    // Operands handed to the shared multiplier
    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

endpackage

### rtl/mip_chain_pitch_layout_unit.sv
// Top level of the mip chain pitch layout block.
//
// One request on i_req (valid/ready) describes a texture: base width and
// height, bytes per texel, layer count and mip level count. The block
// answers on o_res (valid/ready) with one result per mip level, from the
// highest level index down to level 0; the level 0 result has last set and
// carries the layer stride and the total byte size over all layers. A bad
// geometry gives one result with error and last set and all else zero.
// Each level runs the steps row bytes, pitch and area product, accumulate
// and emit, and level 0 adds the stride times layer count product, which
// runs in two halves through the one shared 20x16 multiplier. A rejected
// item goes straight from idle to the emit step.
// o_req_ready is high only while the sequencer is idle. A finished result
// waits in the output register; a stalled receiver holds the sequencer in
// its emit step, and the next request may be accepted while the final
// result of the previous one is still waiting.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and
// drops any pending result.
module mip_chain_pitch_layout_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  mcpl_pkg::t_req   i_req,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output mcpl_pkg::t_res   o_res
);
    import mcpl_pkg::*;

    t_mul_req          mul_op;
    logic [PROD_W-1:0] mul_prod;
    logic              idle;
    logic              out_free;
    logic              push;
    t_res              res;
    logic              r_out_valid;
    t_res              r_out;

    mcpl_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .o_prod (mul_prod)
    );

    mcpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_req_valid && idle),
        .i_req      (i_req),
        .o_idle     (idle),
        .o_mul      (mul_op),
        .i_prod     (mul_prod),
        .i_out_free (out_free),
        .o_push     (push),
        .o_res      (res)
    );

    assign out_free = !r_out_valid || i_res_ready;

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && push) begin
            r_out <= res;
        end
    end

    assign o_req_ready = idle;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

### rtl/mcpl_mul.sv
// Shared unsigned multiplier with a registered product.
module mcpl_mul (
    input  logic                         i_clk,
    input  mcpl_pkg::t_mul_req           i_op,
    output logic [mcpl_pkg::PROD_W-1:0]  o_prod
);
    import mcpl_pkg::*;

    logic [PROD_W-1:0] r_prod;

    // Register the product every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_op.a) * PROD_W'(i_op.b);
    end

    assign o_prod = r_prod;

endmodule

### rtl/mcpl_ctrl.sv
// Sequencer that walks the mip levels and drives the shared multiplier.
module mcpl_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  mcpl_pkg::t_req              i_req,
    output logic                        o_idle,
    output mcpl_pkg::t_mul_req          o_mul,
    input  logic [mcpl_pkg::PROD_W-1:0] i_prod,
    input  logic                        i_out_free,
    output logic                        o_push,
    output mcpl_pkg::t_res              o_res
);
    import mcpl_pkg::*;

    localparam logic [PITCH_W-1:0] ALIGN_MASK = PITCH_W'(PITCH_ALIGN - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_AREA,
        S_ACC,
        S_STR_LO,
        S_STR_HI,
        S_STR_ADD,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic [DIM_W-1:0]     r_w;
    logic [DIM_W-1:0]     r_h;
    logic [TB_W-1:0]      r_tb;
    logic [LAYER_W-1:0]   r_layers;
    logic [LVL_W-1:0]     r_lvl;
    logic                 r_err;
    logic [SUM_W-1:0]     r_offset;
    logic [SUM_W-1:0]     r_sum;
    logic [DIM_W-1:0]     r_lw;
    logic [DIM_W-1:0]     r_lh;
    logic [PITCH_W-1:0]   r_pitch;
    logic [2*HALF_W-3:0]  r_tlo;
    logic [TOTAL_W-1:0]   r_total;

    logic                 bad_geom;
    logic [DIM_W-1:0]     lw;
    logic [DIM_W-1:0]     lh;
    logic [PITCH_W-1:0]   pitch;

    // Ceiling of v divided by 2^s
    function automatic logic [DIM_W-1:0] ceil_shr(input logic [DIM_W-1:0] v,
                                                   input logic [LVL_W-1:0] s);
        logic [DIM_W:0] t;
        t = {1'b0, v} + (((DIM_W+1)'(1) << s) - (DIM_W+1)'(1));
        return DIM_W'(t >> s);
    endfunction

    // Check the incoming geometry
    always_comb begin
        bad_geom = (i_req.tex_width == '0) || (i_req.tex_height == '0) ||
                   (i_req.texel_bytes == '0) || (i_req.layer_count == '0) ||
                   (i_req.mip_levels == '0) ||
                   ({1'b0, i_req.mip_levels} > (LVL_W+1)'(MAX_MIP_LEVELS)) ||
                   ({1'b0, i_req.tex_width} > (DIM_W+1)'(MAX_DIMENSION)) ||
                   ({1'b0, i_req.tex_height} > (DIM_W+1)'(MAX_DIMENSION));
    end

    // Level size and aligned pitch
    assign lw    = ceil_shr(r_w, r_lvl);
    assign lh    = ceil_shr(r_h, r_lvl);
    assign pitch = (i_prod[PITCH_W-1:0] + ALIGN_MASK) & ~ALIGN_MASK;

    // Pick multiplier operands for the current step
    always_comb begin
        o_mul = '0;
        case (r_state)
            S_ROW: begin
                o_mul.a = MUL_A_W'(lw);
                o_mul.b = MUL_B_W'(r_tb);
            end
            S_AREA: begin
                o_mul.a = MUL_A_W'(pitch);
                o_mul.b = MUL_B_W'(r_lh);
            end
            S_STR_LO: begin
                o_mul.a = MUL_A_W'(r_sum[HALF_W-1:0]);
                o_mul.b = r_layers;
            end
            S_STR_HI: begin
                o_mul.a = MUL_A_W'(r_sum[SUM_W-1:HALF_W]);
                o_mul.b = r_layers;
            end
            default: begin
                o_mul = '0;
            end
        endcase
    end

    // Sequence the level walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lvl    <= '0;
            r_err    <= 1'b0;
            r_offset <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_w      <= i_req.tex_width;
                        r_h      <= i_req.tex_height;
                        r_tb     <= i_req.texel_bytes;
                        r_layers <= i_req.layer_count;
                        r_lvl    <= i_req.mip_levels - LVL_W'(1);
                        r_offset <= '0;
                        r_err    <= bad_geom;
                        r_state  <= bad_geom ? S_EMIT : S_ROW;
                    end
                end
                S_ROW: begin
                    r_lw    <= lw;
                    r_lh    <= lh;
                    r_state <= S_AREA;
                end
                S_AREA: begin
                    r_pitch <= pitch;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum   <= r_offset + i_prod;
                    r_state <= (r_lvl == '0) ? S_STR_LO : S_EMIT;
                end
                S_STR_LO: begin
                    r_state <= S_STR_HI;
                end
                S_STR_HI: begin
                    r_tlo   <= i_prod[2*HALF_W-3:0];
                    r_state <= S_STR_ADD;
                end
                S_STR_ADD: begin
                    r_total <= TOTAL_W'(r_tlo) +
                               {i_prod[TOTAL_W-HALF_W-1:0], {HALF_W{1'b0}}};
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_out_free) begin
                        if (r_err || (r_lvl == '0)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_lvl    <= r_lvl - LVL_W'(1);
                            r_offset <= r_sum;
                            r_state  <= S_ROW;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Build the result of the current level
    always_comb begin
        o_res = '0;
        if (r_err) begin
            o_res.error = 1'b1;
            o_res.last  = 1'b1;
        end else begin
            o_res.level_index  = r_lvl;
            o_res.level_offset = r_offset[OFFSET_W-1:0];
            o_res.line_pitch   = r_pitch;
            o_res.level_width  = r_lw;
            o_res.level_height = r_lh;
            if (r_lvl == '0) begin
                o_res.chain_bytes = r_sum[OFFSET_W-1:0];
                o_res.total_bytes = r_total;
                o_res.last        = 1'b1;
            end
        end
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_push = (r_state == S_EMIT) && i_out_free;

    // A final push returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_res.last |=> r_state == S_IDLE)
        else $error("sequencer not idle after final result");

    // Only level 0 or an error closes an item
    a_last_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && !o_res.last |-> !o_res.error && (o_res.level_index != '0))
        else $error("non-final result at level 0");

    // Error results carry no geometry
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_res.error |-> o_res.last && (o_res.line_pitch == '0) &&
                                  (o_res.total_bytes == '0))
        else $error("error result carries data");

    // Levels are emitted in descending order within one item
    a_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && !o_res.last |=> r_state == S_ROW && r_lvl == $past(r_lvl) - 4'd1)
        else $error("level index did not step down");

endmodule
